FILE: hdl/ocd_pkg.sv
// ============================================================================
// ocd_pkg
// Shared types and class codes for the opcode class decoder.
// ============================================================================
package ocd_pkg;

    // Prefix byte values: no prefix, and the one that selects the bit-operation page.
    localparam logic [7:0] PREFIX_NONE = 8'h00;
    localparam logic [7:0] PREFIX_CB   = 8'hCB;

    // Instruction class codes.
    localparam logic [5:0] K_NOP        = 6'd0;
    localparam logic [5:0] K_LD_NN_SP   = 6'd1;
    localparam logic [5:0] K_STOP       = 6'd2;
    localparam logic [5:0] K_JR         = 6'd3;
    localparam logic [5:0] K_JR_CC      = 6'd4;
    localparam logic [5:0] K_LD_RP_NN   = 6'd5;
    localparam logic [5:0] K_ADD_HL_RP  = 6'd6;
    localparam logic [5:0] K_ST_IND_A   = 6'd7;
    localparam logic [5:0] K_LD_A_IND   = 6'd8;
    localparam logic [5:0] K_LDI_HL_A   = 6'd9;
    localparam logic [5:0] K_LDI_A_HL   = 6'd10;
    localparam logic [5:0] K_LDD_HL_A   = 6'd11;
    localparam logic [5:0] K_LDD_A_HL   = 6'd12;
    localparam logic [5:0] K_INC_RP     = 6'd13;
    localparam logic [5:0] K_DEC_RP     = 6'd14;
    localparam logic [5:0] K_INC_R      = 6'd15;
    localparam logic [5:0] K_DEC_R      = 6'd16;
    localparam logic [5:0] K_LD_R_N     = 6'd17;
    localparam logic [5:0] K_RLCA       = 6'd18;
    localparam logic [5:0] K_HALT       = 6'd26;
    localparam logic [5:0] K_LD_R_R     = 6'd27;
    localparam logic [5:0] K_ALU_R      = 6'd28;
    localparam logic [5:0] K_LDH_N_A    = 6'd29;
    localparam logic [5:0] K_RET_CC     = 6'd33;
    localparam logic [5:0] K_POP        = 6'd34;
    localparam logic [5:0] K_RET        = 6'd35;
    localparam logic [5:0] K_LDH_C_A    = 6'd39;
    localparam logic [5:0] K_JP_CC      = 6'd43;
    localparam logic [5:0] K_JP_NN      = 6'd44;
    localparam logic [5:0] K_CB_PREFIX  = 6'd45;
    localparam logic [5:0] K_DI         = 6'd46;
    localparam logic [5:0] K_EI         = 6'd47;
    localparam logic [5:0] K_CALL_CC    = 6'd48;
    localparam logic [5:0] K_PUSH       = 6'd49;
    localparam logic [5:0] K_CALL_NN    = 6'd50;
    localparam logic [5:0] K_ALU_N      = 6'd51;
    localparam logic [5:0] K_RST        = 6'd52;
    localparam logic [5:0] K_CB_SHIFT   = 6'd53;
    localparam logic [5:0] K_CB_BIT     = 6'd54;
    localparam logic [5:0] K_ILLEGAL    = 6'd57;
    localparam logic [5:0] K_BAD_PREFIX = 6'd58;

    // Fixed pair index used by the LDI and LDD forms (HL).
    localparam logic [1:0] PAIR_HL = 2'd2;

    // Immediate byte counts.
    localparam logic [1:0] IMM_NONE = 2'd0;
    localparam logic [1:0] IMM_BYTE = 2'd1;
    localparam logic [1:0] IMM_WORD = 2'd2;

    // One input word: prefix and opcode bytes.
    typedef struct packed {
        logic [7:0] prefix;
        logic [7:0] opcode;
    } ocd_word_t;

    // One decoded result word.
    typedef struct packed {
        logic [5:0] kind;
        logic [2:0] reg_first;
        logic [2:0] reg_second;
        logic [1:0] pair_index;
        logic [1:0] condition;
        logic [2:0] alu_op;
        logic [2:0] shift_op;
        logic [2:0] bit_index;
        logic [5:0] restart_vector;
        logic [1:0] imm_bytes;
        logic       illegal;
        logic       bad_prefix;
    } ocd_result_t;

endpackage

FILE: hdl/ocd_in_if.sv
// ============================================================================
// ocd_in_if
// Valid/ready channel that carries one prefix and opcode word.
// ============================================================================
interface ocd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] prefix;
    logic [7:0] opcode;

    modport source (output valid, output prefix, output opcode, input ready);
    modport sink   (input valid, input prefix, input opcode, output ready);
endinterface

FILE: hdl/ocd_out_if.sv
// ============================================================================
// ocd_out_if
// Valid/ready channel that carries one decoded result word.
// ============================================================================
interface ocd_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] kind;
    logic [2:0] reg_first;
    logic [2:0] reg_second;
    logic [1:0] pair_index;
    logic [1:0] condition;
    logic [2:0] alu_op;
    logic [2:0] shift_op;
    logic [2:0] bit_index;
    logic [5:0] restart_vector;
    logic [1:0] imm_bytes;
    logic       illegal;
    logic       bad_prefix;

    modport source (
        output valid, output kind, output reg_first, output reg_second,
        output pair_index, output condition, output alu_op, output shift_op,
        output bit_index, output restart_vector, output imm_bytes,
        output illegal, output bad_prefix,
        input ready
    );
    modport sink (
        input valid, input kind, input reg_first, input reg_second,
        input pair_index, input condition, input alu_op, input shift_op,
        input bit_index, input restart_vector, input imm_bytes,
        input illegal, input bad_prefix,
        output ready
    );
endinterface

FILE: hdl/ocd_in_stage.sv
// ============================================================================
// ocd_in_stage
// Input register: captures one prefix/opcode word per cycle while the stage is not stalled downstream.
// ============================================================================
module ocd_in_stage
    import ocd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ocd_in_if.sink    cmd,
    input  logic      down_ready,
    output logic      valid,
    output ocd_word_t word
);

    logic      valid_reg;
    logic      valid_next;
    ocd_word_t word_reg;
    logic      load;

    // The stage takes a new word when empty or when its word moves on.
    assign cmd.ready = !valid_reg || down_ready;
    assign load      = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid bit under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.prefix <= cmd.prefix;
            word_reg.opcode <= cmd.opcode;
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

FILE: hdl/ocd_decode.sv
// ============================================================================
// ocd_decode
// Combinational opcode split and class decode.
// ============================================================================
module ocd_decode
    import ocd_pkg::*;
(
    input  ocd_word_t   word,
    output ocd_result_t result
);

    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;

    assign x = word.opcode[7:6];
    assign y = word.opcode[5:3];
    assign z = word.opcode[2:0];
    assign p = y[2:1];
    assign q = y[0];

    // Fields a class does not use stay zero.
    always_comb
    begin
        result = '0;
        if (word.prefix == PREFIX_NONE)
        begin
            case (x)
                2'd0:
                begin
                    case (z)
                        3'd0:
                        begin
                            case (y)
                                3'd0: result.kind = K_NOP;
                                3'd1:
                                begin
                                    result.kind      = K_LD_NN_SP;
                                    result.imm_bytes = IMM_WORD;
                                end
                                3'd2:
                                begin
                                    result.kind      = K_STOP;
                                    result.imm_bytes = IMM_BYTE;
                                end
                                3'd3:
                                begin
                                    result.kind      = K_JR;
                                    result.imm_bytes = IMM_BYTE;
                                end
                                default:
                                begin
                                    result.kind      = K_JR_CC;
                                    result.condition = y[1:0];
                                    result.imm_bytes = IMM_BYTE;
                                end
                            endcase
                        end
                        3'd1:
                        begin
                            result.kind       = q ? K_ADD_HL_RP : K_LD_RP_NN;
                            result.pair_index = p;
                            result.imm_bytes  = q ? IMM_NONE : IMM_WORD;
                        end
                        3'd2:
                        begin
                            if (p inside {2'd0, 2'd1})
                            begin
                                result.kind       = q ? K_LD_A_IND : K_ST_IND_A;
                                result.pair_index = p;
                            end
                            else if (p == 2'd2)
                            begin
                                result.kind       = q ? K_LDI_A_HL : K_LDI_HL_A;
                                result.pair_index = PAIR_HL;
                            end
                            else
                            begin
                                result.kind       = q ? K_LDD_A_HL : K_LDD_HL_A;
                                result.pair_index = PAIR_HL;
                            end
                        end
                        3'd3:
                        begin
                            result.kind       = q ? K_DEC_RP : K_INC_RP;
                            result.pair_index = p;
                        end
                        3'd4:
                        begin
                            result.kind      = K_INC_R;
                            result.reg_first = y;
                        end
                        3'd5:
                        begin
                            result.kind      = K_DEC_R;
                            result.reg_first = y;
                        end
                        3'd6:
                        begin
                            result.kind      = K_LD_R_N;
                            result.reg_first = y;
                            result.imm_bytes = IMM_BYTE;
                        end
                        default: result.kind = K_RLCA + {3'b000, y};
                    endcase
                end
                2'd1:
                begin
                    if (y == 3'd6 && z == 3'd6)
                    begin
                        result.kind = K_HALT;
                    end
                    else
                    begin
                        result.kind       = K_LD_R_R;
                        result.reg_first  = y;
                        result.reg_second = z;
                    end
                end
                2'd2:
                begin
                    result.kind      = K_ALU_R;
                    result.alu_op    = y;
                    result.reg_first = z;
                end
                default:
                begin
                    case (z)
                        3'd0:
                        begin
                            if (!y[2])
                            begin
                                result.kind      = K_RET_CC;
                                result.condition = y[1:0];
                            end
                            else
                            begin
                                result.kind      = K_LDH_N_A + {4'b0000, y[1:0]};
                                result.imm_bytes = IMM_BYTE;
                            end
                        end
                        3'd1:
                        begin
                            if (!q)
                            begin
                                result.kind       = K_POP;
                                result.pair_index = p;
                            end
                            else
                            begin
                                result.kind = K_RET + {4'b0000, p};
                            end
                        end
                        3'd2:
                        begin
                            if (!y[2])
                            begin
                                result.kind      = K_JP_CC;
                                result.condition = y[1:0];
                                result.imm_bytes = IMM_WORD;
                            end
                            else
                            begin
                                // The absolute-address forms carry a 16-bit address.
                                result.kind      = K_LDH_C_A + {4'b0000, y[1:0]};
                                result.imm_bytes = q ? IMM_WORD : IMM_NONE;
                            end
                        end
                        3'd3:
                        begin
                            case (y)
                                3'd0:
                                begin
                                    result.kind      = K_JP_NN;
                                    result.imm_bytes = IMM_WORD;
                                end
                                3'd1: result.kind = K_CB_PREFIX;
                                3'd6: result.kind = K_DI;
                                3'd7: result.kind = K_EI;
                                default:
                                begin
                                    result.kind    = K_ILLEGAL;
                                    result.illegal = 1'b1;
                                end
                            endcase
                        end
                        3'd4:
                        begin
                            if (!y[2])
                            begin
                                result.kind      = K_CALL_CC;
                                result.condition = y[1:0];
                                result.imm_bytes = IMM_WORD;
                            end
                            else
                            begin
                                result.kind    = K_ILLEGAL;
                                result.illegal = 1'b1;
                            end
                        end
                        3'd5:
                        begin
                            if (!q)
                            begin
                                result.kind       = K_PUSH;
                                result.pair_index = p;
                            end
                            else if (p == 2'd0)
                            begin
                                result.kind      = K_CALL_NN;
                                result.imm_bytes = IMM_WORD;
                            end
                            else
                            begin
                                result.kind    = K_ILLEGAL;
                                result.illegal = 1'b1;
                            end
                        end
                        3'd6:
                        begin
                            result.kind      = K_ALU_N;
                            result.alu_op    = y;
                            result.imm_bytes = IMM_BYTE;
                        end
                        default:
                        begin
                            result.kind           = K_RST;
                            result.restart_vector = {y, 3'b000};
                        end
                    endcase
                end
            endcase
        end
        else if (word.prefix == PREFIX_CB)
        begin
            // Bit-operation page: the operand register is always z.
            result.reg_first = z;
            if (x == 2'd0)
            begin
                result.kind     = K_CB_SHIFT;
                result.shift_op = y;
            end
            else
            begin
                result.kind      = K_CB_BIT + {4'b0000, x - 2'd1};
                result.bit_index = y;
            end
        end
        else
        begin
            result.kind       = K_BAD_PREFIX;
            result.bad_prefix = 1'b1;
        end
    end

endmodule

FILE: hdl/ocd_out_stage.sv
// ============================================================================
// ocd_out_stage
// Result register: holds one decoded word until the sink takes it.
// ============================================================================
module ocd_out_stage
    import ocd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  ocd_result_t result,
    output logic        ready,
    ocd_out_if.source   res
);

    logic        valid_reg;
    logic        valid_next;
    ocd_result_t result_reg;
    logic        load;

    // Empty or draining this cycle: a new result may enter.
    assign ready = !valid_reg || res.ready;
    assign load  = valid && ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid bit under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    // Drive the channel from the held word.
    assign res.valid          = valid_reg;
    assign res.kind           = result_reg.kind;
    assign res.reg_first      = result_reg.reg_first;
    assign res.reg_second     = result_reg.reg_second;
    assign res.pair_index     = result_reg.pair_index;
    assign res.condition      = result_reg.condition;
    assign res.alu_op         = result_reg.alu_op;
    assign res.shift_op       = result_reg.shift_op;
    assign res.bit_index      = result_reg.bit_index;
    assign res.restart_vector = result_reg.restart_vector;
    assign res.imm_bytes      = result_reg.imm_bytes;
    assign res.illegal        = result_reg.illegal;
    assign res.bad_prefix     = result_reg.bad_prefix;

endmodule

FILE: hdl/cpu_opcode_class_decoder_unit.sv
// ============================================================================
// cpu_opcode_class_decoder_unit
// Path: a word accepted on cmd is held in the input register, decoded, and
// captured in the result register, where it is valid on res until taken.
// Throughput: one word per cycle while res.ready stays high; the input and result registers each hold
// one word, and the decode between them is a single short logic pass.
// Reset: rst_n clears both valid bits at once; no word is in flight after it.
// ============================================================================
module cpu_opcode_class_decoder_unit
    import ocd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ocd_in_if.sink    cmd,
    ocd_out_if.source res
);

    logic        s1_valid;
    logic        s2_ready;
    ocd_word_t   s1_word;
    ocd_result_t dec_result;

    // Input register.
    ocd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .down_ready (s2_ready),
        .valid      (s1_valid),
        .word       (s1_word)
    );

    // Decode logic.
    ocd_decode u_decode (
        .word   (s1_word),
        .result (dec_result)
    );

    // Result register.
    ocd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (s1_valid),
        .result (dec_result),
        .ready  (s2_ready),
        .res    (res)
    );

`ifndef SYNTHESIS
    // An empty input register always takes a word.
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid |-> cmd.ready)
        else $error("input stage empty but not ready");

    // A held input word that cannot move on stays in place.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_word)))
        else $error("input stage lost or changed a stalled word");

    // A word in the input register with room downstream shows up next cycle.
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s2_ready) |=> res.valid)
        else $error("decoded word did not reach the result register");

    // The illegal flag only comes with its own class and a good prefix.
    a_illegal_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.illegal) |-> (res.kind == K_ILLEGAL && !res.bad_prefix))
        else $error("illegal flag with wrong class");

    // A bad prefix clears every selector.
    a_bad_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.bad_prefix) |->
            (res.kind == K_BAD_PREFIX && res.imm_bytes == IMM_NONE
             && res.reg_first == 3'd0))
        else $error("bad prefix result not clean");
`endif

endmodule

FILE: sim/ocd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ocd_checker
// Passive monitor for the opcode class decoder. It watches both channels,
// works out the decoded word for every accepted input word, and compares
// each accepted result word against the oldest outstanding expectation.
// ============================================================================
module ocd_checker
    import ocd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ocd_in_if    cmd,
    ocd_out_if   res,
    output int   errors,
    output int   outstanding
);

    ocd_result_t expected_q[$];
    ocd_word_t   source_q[$];
    int          result_count;

    // Decode one prefix and opcode pair into the class code and operand fields.
    function automatic ocd_result_t decode_word(logic [7:0] pre, logic [7:0] op);
        ocd_result_t r;
        logic [1:0]  x;
        logic [2:0]  y;
        logic [2:0]  z;
        logic [1:0]  p;
        logic        q;
        r = '0;
        x = op[7:6];
        y = op[5:3];
        z = op[2:0];
        p = y[2:1];
        q = y[0];
        if (pre == PREFIX_CB)
        begin
            // Bit-operation page: the source register always comes from z.
            r.reg_first = z;
            if (x == 2'd0)
            begin
                r.kind     = K_CB_SHIFT;
                r.shift_op = y;
            end
            else
            begin
                r.kind      = K_CB_BIT + {4'd0, x} - 6'd1;
                r.bit_index = y;
            end
        end
        else if (pre != PREFIX_NONE)
        begin
            r.kind       = K_BAD_PREFIX;
            r.bad_prefix = 1'b1;
        end
        else if (x == 2'd0)
        begin
            case (z)
                3'd0:
                begin
                    if (y == 3'd0)
                        r.kind = K_NOP;
                    else if (y == 3'd1)
                    begin
                        r.kind      = K_LD_NN_SP;
                        r.imm_bytes = IMM_WORD;
                    end
                    else if (y == 3'd2)
                    begin
                        // STOP swallows the padding byte that follows it.
                        r.kind      = K_STOP;
                        r.imm_bytes = IMM_BYTE;
                    end
                    else if (y == 3'd3)
                    begin
                        r.kind      = K_JR;
                        r.imm_bytes = IMM_BYTE;
                    end
                    else
                    begin
                        r.kind      = K_JR_CC;
                        r.condition = y[1:0];
                        r.imm_bytes = IMM_BYTE;
                    end
                end
                3'd1:
                begin
                    r.kind       = q ? K_ADD_HL_RP : K_LD_RP_NN;
                    r.pair_index = p;
                    if (!q)
                        r.imm_bytes = IMM_WORD;
                end
                3'd2:
                begin
                    if (p < 2'd2)
                    begin
                        r.kind       = q ? K_LD_A_IND : K_ST_IND_A;
                        r.pair_index = p;
                    end
                    else if (p == 2'd2)
                    begin
                        r.kind       = q ? K_LDI_A_HL : K_LDI_HL_A;
                        r.pair_index = PAIR_HL;
                    end
                    else
                    begin
                        r.kind       = q ? K_LDD_A_HL : K_LDD_HL_A;
                        r.pair_index = PAIR_HL;
                    end
                end
                3'd3:
                begin
                    r.kind       = q ? K_DEC_RP : K_INC_RP;
                    r.pair_index = p;
                end
                3'd4:
                begin
                    r.kind      = K_INC_R;
                    r.reg_first = y;
                end
                3'd5:
                begin
                    r.kind      = K_DEC_R;
                    r.reg_first = y;
                end
                3'd6:
                begin
                    r.kind      = K_LD_R_N;
                    r.reg_first = y;
                    r.imm_bytes = IMM_BYTE;
                end
                default:
                    r.kind = K_RLCA + {3'd0, y};
            endcase
        end
        else if (x == 2'd1)
        begin
            // The (HL),(HL) slot of the load block is HALT.
            if (y == 3'd6 && z == 3'd6)
                r.kind = K_HALT;
            else
            begin
                r.kind       = K_LD_R_R;
                r.reg_first  = y;
                r.reg_second = z;
            end
        end
        else if (x == 2'd2)
        begin
            r.kind      = K_ALU_R;
            r.alu_op    = y;
            r.reg_first = z;
        end
        else
        begin
            case (z)
                3'd0:
                begin
                    if (y < 3'd4)
                    begin
                        r.kind      = K_RET_CC;
                        r.condition = y[1:0];
                    end
                    else
                    begin
                        r.kind      = K_LDH_N_A + {4'd0, y[1:0]};
                        r.imm_bytes = IMM_BYTE;
                    end
                end
                3'd1:
                begin
                    if (!q)
                    begin
                        r.kind       = K_POP;
                        r.pair_index = p;
                    end
                    else
                        r.kind = K_RET + {4'd0, p};
                end
                3'd2:
                begin
                    if (y < 3'd4)
                    begin
                        r.kind      = K_JP_CC;
                        r.condition = y[1:0];
                        r.imm_bytes = IMM_WORD;
                    end
                    else
                    begin
                        r.kind = K_LDH_C_A + {4'd0, y[1:0]};
                        if (y == 3'd5 || y == 3'd7)
                            r.imm_bytes = IMM_WORD;
                    end
                end
                3'd3:
                begin
                    if (y == 3'd0)
                    begin
                        r.kind      = K_JP_NN;
                        r.imm_bytes = IMM_WORD;
                    end
                    else if (y == 3'd1)
                        r.kind = K_CB_PREFIX;
                    else if (y == 3'd6)
                        r.kind = K_DI;
                    else if (y == 3'd7)
                        r.kind = K_EI;
                    else
                    begin
                        r.kind    = K_ILLEGAL;
                        r.illegal = 1'b1;
                    end
                end
                3'd4:
                begin
                    if (y < 3'd4)
                    begin
                        r.kind      = K_CALL_CC;
                        r.condition = y[1:0];
                        r.imm_bytes = IMM_WORD;
                    end
                    else
                    begin
                        r.kind    = K_ILLEGAL;
                        r.illegal = 1'b1;
                    end
                end
                3'd5:
                begin
                    if (!q)
                    begin
                        r.kind       = K_PUSH;
                        r.pair_index = p;
                    end
                    else if (p == 2'd0)
                    begin
                        r.kind      = K_CALL_NN;
                        r.imm_bytes = IMM_WORD;
                    end
                    else
                    begin
                        r.kind    = K_ILLEGAL;
                        r.illegal = 1'b1;
                    end
                end
                3'd6:
                begin
                    r.kind      = K_ALU_N;
                    r.alu_op    = y;
                    r.imm_bytes = IMM_BYTE;
                end
                default:
                begin
                    r.kind           = K_RST;
                    r.restart_vector = {y, 3'b000};
                end
            endcase
        end
        return r;
    endfunction

    // Compact text form of a result word for error reports.
    function automatic string fmt_result(ocd_result_t r);
        return {$sformatf("kind=%0d r1=%0d r2=%0d rp=%0d cc=%0d alu=%0d ",
                          r.kind, r.reg_first, r.reg_second, r.pair_index,
                          r.condition, r.alu_op),
                $sformatf("sh=%0d bit=%0d rst=%0d imm=%0d ill=%0b badp=%0b",
                          r.shift_op, r.bit_index, r.restart_vector,
                          r.imm_bytes, r.illegal, r.bad_prefix)};
    endfunction

    // Record accepted input words and check accepted result words.
    always @(posedge clk or negedge rst_n)
    begin : watch
        ocd_result_t got;
        ocd_result_t want;
        ocd_word_t   src;
        bit          bad;
        if (!rst_n)
        begin
            expected_q.delete();
            source_q.delete();
            result_count <= 0;
            errors       <= 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                src.prefix = cmd.prefix;
                src.opcode = cmd.opcode;
                expected_q.push_back(decode_word(cmd.prefix, cmd.opcode));
                source_q.push_back(src);
            end
            if (res.valid && res.ready)
            begin
                got.kind           = res.kind;
                got.reg_first      = res.reg_first;
                got.reg_second     = res.reg_second;
                got.pair_index     = res.pair_index;
                got.condition      = res.condition;
                got.alu_op         = res.alu_op;
                got.shift_op       = res.shift_op;
                got.bit_index      = res.bit_index;
                got.restart_vector = res.restart_vector;
                got.imm_bytes      = res.imm_bytes;
                got.illegal        = res.illegal;
                got.bad_prefix     = res.bad_prefix;
                if (expected_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("[%0t] unexpected result word: %s", $realtime, fmt_result(got));
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    src  = source_q.pop_front();
                    bad  = (got.kind !== want.kind) ||
                           (got.reg_first !== want.reg_first) ||
                           (got.reg_second !== want.reg_second) ||
                           (got.pair_index !== want.pair_index) ||
                           (got.condition !== want.condition) ||
                           (got.alu_op !== want.alu_op) ||
                           (got.shift_op !== want.shift_op) ||
                           (got.bit_index !== want.bit_index) ||
                           (got.restart_vector !== want.restart_vector) ||
                           (got.imm_bytes !== want.imm_bytes) ||
                           (got.illegal !== want.illegal) ||
                           (got.bad_prefix !== want.bad_prefix);
                    if (bad)
                    begin
                        if (errors < 10)
                        begin
                            $display("[%0t] decode error on word %0d, prefix %02h opcode %02h",
                                     $realtime, result_count, src.prefix, src.opcode);
                            $display("    expected: %s", fmt_result(want));
                            $display("    actual:   %s", fmt_result(got));
                        end
                        errors <= errors + 1;
                    end
                end
                result_count <= result_count + 1;
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Top level for the opcode class decoder test. It drives directed corner
// words, a shuffled sweep of both opcode pages and random words, with random
// gaps on both channels, and reports the verdict from the checker.
// ============================================================================
module tb;
    import ocd_pkg::*;

    localparam int N_DIRECTED = 23;
    localparam int N_SWEEP    = 512;
    localparam int N_RANDOM   = 320;

    // Corner words: extremes, STOP, the prefix opcode, HALT, every missing
    // opcode, the bit page edges and several invalid prefixes.
    localparam logic [15:0] DIRECTED_WORDS [N_DIRECTED] = '{
        16'h0000, 16'h00FF, 16'h0010, 16'h00CB, 16'h0076,
        16'h00D3, 16'h00DB, 16'h00DD, 16'h00E3, 16'h00E4, 16'h00EB,
        16'h00EC, 16'h00ED, 16'h00F4, 16'h00FC, 16'h00FD,
        16'hCB00, 16'hCBFF, 16'hCB36,
        16'h0100, 16'hFFFF, 16'hCACB, 16'hCC7F
    };

    logic      clk;
    logic      rst_n;
    bit        calm;
    int        errors;
    int        outstanding;
    ocd_word_t sweep_words [N_SWEEP];

    ocd_in_if  cmd ();
    ocd_out_if res ();

    cpu_opcode_class_decoder_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    ocd_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Clock generator.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Present one word, with random gaps before it, and hold it until taken.
    task automatic send_word(input logic [7:0] pre, input logic [7:0] op);
        while (!calm && $urandom_range(99) < 13)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid  <= 1'b1;
        cmd.prefix <= pre;
        cmd.opcode <= op;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding result word has come back.
    task automatic drain;
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Result side back-pressure.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        ocd_word_t tmp;
        int        j;
        int        pick;
        logic [7:0] pre;
        rst_n      = 1'b0;
        calm       = 1'b0;
        cmd.valid  = 1'b0;
        cmd.prefix = 8'h00;
        cmd.opcode = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner words.
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED_WORDS[i][15:8], DIRECTED_WORDS[i][7:0]);

        // Every opcode of both pages, in shuffled order.
        for (int i = 0; i < N_SWEEP; i++)
        begin
            sweep_words[i].prefix = i[8] ? PREFIX_CB : PREFIX_NONE;
            sweep_words[i].opcode = i[7:0];
        end
        for (int i = N_SWEEP - 1; i > 0; i--)
        begin
            j              = $urandom_range(i);
            tmp            = sweep_words[i];
            sweep_words[i] = sweep_words[j];
            sweep_words[j] = tmp;
        end
        for (int i = 0; i < N_SWEEP; i++)
        begin
            // A long stretch with no gaps on either side.
            if (i == 100)
                calm <= 1'b1;
            if (i == 260)
                calm <= 1'b0;
            send_word(sweep_words[i].prefix, sweep_words[i].opcode);
        end

        // Let the pipeline empty completely before the random words.
        drain();

        // Random words: mostly valid prefixes, the rest any byte at all.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                pre = PREFIX_NONE;
            else if (pick < 75)
                pre = PREFIX_CB;
            else
                pre = 8'($urandom_range(255));
            send_word(pre, 8'($urandom_range(255)));
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
